>>> design/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window.
// Used by the top level, the deadline memory and the port checker.
package gbn_pkg;

   // default sizes for the top level parameters
   localparam int DefMaxWindow = 64;
   localparam int DefSeqBits   = 16;

   // event kinds on the request channel
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_NEWPKT = 2'd1;
   localparam logic [1:0] CMD_ACK    = 2'd2;

   // per-event status codes on the response channel
   localparam logic [1:0] STAT_PLAIN   = 2'd0;
   localparam logic [1:0] STAT_ACK_OK  = 2'd1;
   localparam logic [1:0] STAT_ACK_IGN = 2'd2;
   localparam logic [1:0] STAT_REFUSED = 2'd3;

   // configuration register indexes
   localparam logic CSR_WINDOW  = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   // configuration reset values
   localparam logic [6:0]  WINDOW_RESET  = 7'd8;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // one response item
   typedef struct packed {
      logic        sent_valid;
      logic [15:0] sent_seq;
      logic        timed_out;
      logic [1:0]  event_status;
      logic [6:0]  outstanding;
   } rsp_type;

endpackage

>>> design/gbn_deadline_mem.sv
// Deadline store: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new data.
module gbn_deadline_mem
   import gbn_pkg::*;
#(
   parameter int DEPTH  = DefMaxWindow,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port with write-through bypass
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> design/go_back_n_sender_window.sv
// Go-back-N sender window: top level.
// Depends on gbn_pkg and gbn_deadline_mem.
//
// Usage:
//  - req channel carries one event item per transfer: req_cmd (tick, new
//    packet, ack) and req_ack_seq. An item is taken when req_valid is high
//    and req_stall is low.
//  - rsp channel returns exactly one item per event: the packet sent (if
//    any), the timeout flag, the event status and the in-flight count.
//  - csr port writes window size (index 0) and timeout in ticks (index 1);
//    the user writes only while the block is idle, which the block does not enforce; no read-back.
// Rate and prefetch:
//  - one event per cycle while req_stall is low; the response is registered
//    in the rsp register, or in the skid register while rsp_stall is high.
//  - the deadline of the oldest packet is prefetched from the deadline
//    memory at the next oldest slot, so ticks never wait on the memory port.
// Reset: counters and time clear, window 8, timeout 100. The deadline
//  memory is not cleared; only entries of packets in flight are used.
// Stall: a skid register catches one result while rsp_stall is high;
//  req_stall rises only while the skid register is occupied.
module go_back_n_sender_window
   import gbn_pkg::*;
#(
   parameter int MAX_WINDOW = DefMaxWindow,
   parameter int SEQ_BITS   = DefSeqBits
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_ack_seq,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sent_valid,
   output logic [15:0] rsp_sent_seq,
   output logic        rsp_timed_out,
   output logic [1:0]  rsp_event_status,
   output logic [6:0]  rsp_outstanding,
   // configuration port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(MAX_WINDOW - 1);
   localparam logic [CMP_W-1:0]  WinMax   = CMP_W'(MAX_WINDOW);

   // configuration registers
   logic [6:0]  window_ff;
   logic [15:0] timeout_ff;

   // window state
   logic [31:0]         time_ff, time_in;
   logic [SEQ_BITS-1:0] next_new_ff, next_new_in;
   logic [SEQ_BITS-1:0] next_send_ff, next_send_in;
   logic [SEQ_BITS-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]    in_flight_ff, in_flight_in;
   logic [SLOT_W-1:0]   send_slot_ff, send_slot_in;
   logic [SLOT_W-1:0]   oldest_slot_ff, oldest_slot_in;

   // output register and skid register
   rsp_type rsp_ff, rsp_in;
   rsp_type skid_ff, skid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   // event evaluation
   logic                accept;
   logic [31:0]         oldest_dl;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [31:0]         mem_wdata;
   rsp_type             ev_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW:  window_ff  <= csr_wdata[6:0];
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // event processing: one accepted event resolved per cycle against prefetched deadline
   always_comb begin
      logic [SEQ_BITS-1:0] ack_m;
      logic [SEQ_BITS-1:0] gap_new;
      logic [SEQ_BITS-1:0] send_t;
      logic [CNT_W-1:0]    flight_t;
      logic [SLOT_W-1:0]   sslot_t;
      logic [31:0]         time_t;
      logic [31:0]         age;
      logic [CMP_W-1:0]    win;
      logic [SEQ_BITS-1:0] sseq;
      logic [31:0]         sseq_ext;
      logic                sent;
      logic                timed;
      logic [1:0]          status;

      ack_m    = SEQ_BITS'(32'(req_ack_seq));
      gap_new  = next_new_ff - oldest_ff;
      time_t   = time_ff;
      send_t   = next_send_ff;
      flight_t = in_flight_ff;
      sslot_t  = send_slot_ff;
      timed    = 1'b0;
      status   = STAT_PLAIN;
      sent     = 1'b0;
      sseq     = '0;
      age      = '0;

      next_new_in    = next_new_ff;
      oldest_in      = oldest_ff;
      oldest_slot_in = oldest_slot_ff;

      unique case (req_cmd)
         CMD_TICK: begin
            time_t = time_ff + 32'd1;
            age    = time_t - oldest_dl;
            if ((flight_t != '0) && !age[31]) begin
               send_t   = oldest_ff;
               sslot_t  = oldest_slot_ff;
               flight_t = '0;
               timed    = 1'b1;
            end
         end
         CMD_NEWPKT: begin
            if (gap_new == '1) begin
               status = STAT_REFUSED;
            end else begin
               next_new_in = next_new_ff + SEQ_BITS'(1);
            end
         end
         CMD_ACK: begin
            if ((flight_t != '0) && (ack_m == oldest_ff)) begin
               oldest_in      = oldest_ff + SEQ_BITS'(1);
               oldest_slot_in = (oldest_slot_ff == SlotLast) ? '0
                                : oldest_slot_ff + SLOT_W'(1);
               flight_t       = flight_t - CNT_W'(1);
               status         = STAT_ACK_OK;
            end else begin
               status = STAT_ACK_IGN;
            end
         end
         default: ;
      endcase

      // send check, runs after every event
      win = (CMP_W'(window_ff) > WinMax) ? WinMax : CMP_W'(window_ff);
      mem_wdata = time_t + 32'(timeout_ff);
      if ((next_new_in != send_t) && (CMP_W'(flight_t) < win)) begin
         sent     = 1'b1;
         sseq     = send_t;
         send_t   = send_t + SEQ_BITS'(1);
         flight_t = flight_t + CNT_W'(1);
      end
      // write slot: the slot of the packet sent, after any go-back rewind
      mem_we       = accept && sent;
      mem_waddr    = sslot_t;
      send_slot_in = sslot_t;
      if (sent) begin
         send_slot_in = (sslot_t == SlotLast) ? '0 : sslot_t + SLOT_W'(1);
      end

      time_in      = time_t;
      next_send_in = send_t;
      in_flight_in = flight_t;

      sseq_ext            = 32'(sseq);
      ev_rsp.sent_valid   = sent;
      ev_rsp.sent_seq     = sseq_ext[15:0];
      ev_rsp.timed_out    = timed;
      ev_rsp.event_status = status;
      ev_rsp.outstanding  = 7'(flight_t);

      // state only moves on an accepted item
      if (!accept) begin
         time_in        = time_ff;
         next_new_in    = next_new_ff;
         next_send_in   = next_send_ff;
         oldest_in      = oldest_ff;
         in_flight_in   = in_flight_ff;
         send_slot_in   = send_slot_ff;
         oldest_slot_in = oldest_slot_ff;
      end
   end

   // window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff        <= '0;
         next_new_ff    <= '0;
         next_send_ff   <= '0;
         oldest_ff      <= '0;
         in_flight_ff   <= '0;
         send_slot_ff   <= '0;
         oldest_slot_ff <= '0;
      end else begin
         time_ff        <= time_in;
         next_new_ff    <= next_new_in;
         next_send_ff   <= next_send_in;
         oldest_ff      <= oldest_in;
         in_flight_ff   <= in_flight_in;
         send_slot_ff   <= send_slot_in;
         oldest_slot_ff <= oldest_slot_in;
      end
   end

   // deadline memory; read address follows the next oldest slot
   gbn_deadline_mem #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (SLOT_W),
      .DATA_W (32)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (oldest_slot_in),
      .rd_data (oldest_dl)
   );

   // output register with one-deep skid
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (accept) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_in       = ev_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = ev_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sent_valid   = rsp_ff.sent_valid;
   assign rsp_sent_seq     = rsp_ff.sent_seq;
   assign rsp_timed_out    = rsp_ff.timed_out;
   assign rsp_event_status = rsp_ff.event_status;
   assign rsp_outstanding  = rsp_ff.outstanding;

endmodule

>>> design/gbn_checker.sv
// Port-level checker for the go-back-N sender window, with its bind.
// Depends on gbn_pkg; sees only the top level ports.
module gbn_checker
   import gbn_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_sent_valid,
   input logic [15:0] rsp_sent_seq,
   input logic        rsp_timed_out,
   input logic [1:0]  rsp_event_status,
   input logic [6:0]  rsp_outstanding
);

   // a stalled response item stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response item dropped under stall");

   // no sequence number without a send
   a_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sent_valid |-> rsp_sent_seq == 16'd0)
      else $error("sent_seq set without sent_valid");

   // a timeout only comes from a tick
   a_to_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_event_status == STAT_PLAIN)
      else $error("timeout on a non-tick event");

   // after go-back the window holds at most the one packet just resent
   a_to_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_outstanding == {6'd0, rsp_sent_valid})
      else $error("in-flight count wrong after timeout");

   // no response item right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

>>> bench/gbn_bench_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the go-back-N sender window bench: predicts every response
// item from the accepted request items. Depends on gbn_pkg.
package gbn_bench_pkg;
   import gbn_pkg::*;

   // cmd code that names no event kind
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [6:0]  WindowCap   = 7'(DefMaxWindow);
   localparam logic [15:0] BacklogFull = 16'hFFFF;

   class sender_window_scoreboard;
      // configuration copy
      logic [6:0]  window;
      logic [15:0] timeout;
      // window state copy
      logic [31:0] now;
      logic [31:0] deadline [DefMaxWindow];
      logic [15:0] next_new;
      logic [15:0] next_send;
      logic [15:0] oldest;
      logic [6:0]  in_flight;
      // predicted response items, oldest first
      rsp_type     awaited_rsp [$];
      int          errors;

      function new();
         window    = WINDOW_RESET;
         timeout   = TIMEOUT_RESET;
         now       = '0;
         next_new  = '0;
         next_send = '0;
         oldest    = '0;
         in_flight = '0;
         errors    = 0;
      endfunction

      function void set_register(logic index, logic [15:0] data);
         if (index == CSR_WINDOW)
            window = data[6:0];
         else
            timeout = data;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      // packets not yet acknowledged, in flight or waiting
      function logic [15:0] backlog();
         logic [15:0] gap;
         gap = next_new - oldest;
         return gap;
      endfunction

      // advance the window by one accepted item and queue its response
      function void note_event(logic [1:0] cmd, logic [15:0] ack);
         rsp_type     r;
         logic [6:0]  win;
         logic [31:0] age;
         r = '0;
         r.event_status = STAT_PLAIN;
         win = (window > WindowCap) ? WindowCap : window;
         case (cmd)
            CMD_TICK: begin
               now = now + 32'd1;
               if (in_flight != 0) begin
                  // wrap-safe deadline compare
                  age = now - deadline[oldest % DefMaxWindow];
                  if (!age[31]) begin
                     next_send   = oldest;
                     in_flight   = '0;
                     r.timed_out = 1'b1;
                  end
               end
            end
            CMD_NEWPKT: begin
               if (backlog() == BacklogFull)
                  r.event_status = STAT_REFUSED;
               else
                  next_new = next_new + 16'd1;
            end
            CMD_ACK: begin
               if (in_flight != 0 && ack == oldest) begin
                  oldest         = oldest + 16'd1;
                  in_flight      = in_flight - 7'd1;
                  r.event_status = STAT_ACK_OK;
               end else begin
                  r.event_status = STAT_ACK_IGN;
               end
            end
            default: ;
         endcase
         // send at most one waiting packet
         if (next_new != next_send && in_flight < win) begin
            deadline[next_send % DefMaxWindow] = now + {16'd0, timeout};
            r.sent_valid = 1'b1;
            r.sent_seq   = next_send;
            next_send    = next_send + 16'd1;
            in_flight    = in_flight + 7'd1;
         end
         r.outstanding = in_flight;
         awaited_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t: response item with none awaited: expected none, actual seq %0d",
                     $time, got.sent_seq);
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("sent_valid", 16'(want.sent_valid), 16'(got.sent_valid));
         compare_field("sent_seq", want.sent_seq, got.sent_seq);
         compare_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
         compare_field("event_status", 16'(want.event_status), 16'(got.event_status));
         compare_field("outstanding", 16'(want.outstanding), 16'(got.outstanding));
      endfunction
   endclass

endpackage

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top-level bench for go_back_n_sender_window: directed, no-idle and
// random event phases. Depends on gbn_pkg, gbn_bench_pkg and the RTL.
module testbench;
   import gbn_pkg::*;
   import gbn_bench_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [15:0] req_ack_seq;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_sent_valid;
   logic [15:0] rsp_sent_seq;
   logic        rsp_timed_out;
   logic [1:0]  rsp_event_status;
   logic [6:0]  rsp_outstanding;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   bit quiet = 1'b0;   // no idling on either side while set
   sender_window_scoreboard sb;

   go_back_n_sender_window dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_ack_seq      (req_ack_seq),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sent_valid   (rsp_sent_valid),
      .rsp_sent_seq     (rsp_sent_seq),
      .rsp_timed_out    (rsp_timed_out),
      .rsp_event_status (rsp_event_status),
      .rsp_outstanding  (rsp_outstanding),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit, far above the slowest legal run
   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 22);
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response({rsp_sent_valid, rsp_sent_seq, rsp_timed_out,
                               rsp_event_status, rsp_outstanding});
         if (req_valid && !req_stall)
            sb.note_event(req_cmd, req_ack_seq);
      end
   end

   // offer one item; starts and ends at a falling edge
   task automatic send_event(input logic [1:0] cmd, input logic [15:0] ack);
      while (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_ack_seq <= ack;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off until every awaited response item is in
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_register(index, data);
   endtask

   // mostly well-formed traffic: new packets, acks of the oldest, ticks
   task automatic random_phase(input int count);
      int          pick;
      logic [1:0]  cmd;
      logic [15:0] ack;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         ack  = 16'($urandom_range(65535));
         if (pick < 35) begin
            cmd = CMD_NEWPKT;
         end else if (pick < 65) begin
            cmd = CMD_ACK;
            ack = sb.oldest;
         end else if (pick < 88) begin
            cmd = CMD_TICK;
         end else if (pick < 93) begin
            cmd = CMD_ACK;
         end else if (pick < 96) begin
            cmd = CMD_ACK;
            ack = sb.oldest + 16'd1;
         end else begin
            cmd = CMD_UNUSED;
         end
         if ($urandom_range(39) == 0)
            wait_drain();
         send_event(cmd, ack);
      end
   endtask

   initial begin
      logic [6:0]  windows  [8];
      logic [15:0] timeouts [8];
      windows     = '{7'd1, 7'd64, 7'd3, 7'd127, 7'd0, 7'd16, 7'd5, 7'd2};
      timeouts    = '{16'd1, 16'd6, 16'd0, 16'd4, 16'd3, 16'd2, 16'hFFFF, 16'd12};
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_TICK;
      req_ack_seq = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_WINDOW;
      csr_wdata   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty-window acks, unused cmd, tick, packet and acks
      send_event(CMD_ACK, 16'h0000);
      send_event(CMD_ACK, 16'hFFFF);
      send_event(CMD_UNUSED, 16'h5A5A);
      send_event(CMD_TICK, 16'hA5A5);
      send_event(CMD_NEWPKT, 16'h0000);
      send_event(CMD_ACK, 16'h0001);
      send_event(CMD_ACK, 16'h0000);
      wait_drain();

      // one-packet window, zero timeout: next tick goes back
      write_csr(CSR_WINDOW, 16'd1);
      write_csr(CSR_TIMEOUT, 16'd0);
      send_event(CMD_NEWPKT, 16'h0000);
      send_event(CMD_NEWPKT, 16'hFFFF);
      send_event(CMD_TICK, 16'h0000);
      send_event(CMD_ACK, sb.oldest);
      send_event(CMD_ACK, sb.oldest);
      wait_drain();

      // window above the cap saturates
      write_csr(CSR_WINDOW, 16'd127);
      write_csr(CSR_TIMEOUT, 16'd3);
      repeat (5) send_event(CMD_NEWPKT, 16'h0000);
      repeat (4) send_event(CMD_TICK, 16'h0000);
      repeat (5) send_event(CMD_ACK, sb.oldest);
      wait_drain();

      // long run without idling: queue packets, then ack everything back out
      quiet = 1'b1;
      write_csr(CSR_WINDOW, 16'd64);
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      repeat (20) send_event(CMD_NEWPKT, 16'($urandom_range(65535)));
      while (sb.backlog() != 0)
         send_event(CMD_ACK, sb.oldest);
      wait_drain();
      quiet = 1'b0;

      // random traffic over several settings
      for (int p = 0; p < 8; p++) begin
         wait_drain();
         write_csr(CSR_WINDOW, {9'd0, windows[p]});
         write_csr(CSR_TIMEOUT, timeouts[p]);
         random_phase(48);
      end

      wait_drain();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
